// File: src/rsa_keygen_and_decrypt_assert.svh
// ----------------------------------------------------------------------------
// RSA key generation and decryption: assertion macros
// Concurrent check macros that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RSA_KEYGEN_AND_DECRYPT_ASSERT_SVH
`define RSA_KEYGEN_AND_DECRYPT_ASSERT_SVH
`ifndef SYNTHESIS
`define RKD_ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("rkd check failed");
`define RKD_ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("rkd check failed");
`else
`define RKD_ASSERT_RST(lbl, clk, rstn, prop)
`define RKD_ASSERT_CLK(lbl, clk, prop)
`endif
`endif

// File: src/rkd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA key generation and decryption package
// Commands, status codes and the widths of the shared divider.
// ----------------------------------------------------------------------------
package rkd_pkg;

    localparam int DVW = 72;  // dividend and quotient width
    localparam int DSW = 64;  // divisor and remainder width
    localparam int DCW = $clog2(DVW + 1);

    localparam logic CMD_KEYGEN  = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_PRIMES = 2'd1;
    localparam logic [1:0] ST_NO_KEYS    = 2'd2;

endpackage

// File: src/rkd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RKD shared divider
// Restoring divider, one quotient bit per cycle; done pulses after DVW steps.
// ----------------------------------------------------------------------------
module rkd_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [rkd_pkg::DVW-1:0] i_dividend,
    input  logic [rkd_pkg::DSW-1:0] i_divisor,
    output logic                    o_done,
    output logic [rkd_pkg::DVW-1:0] o_quot,
    output logic [rkd_pkg::DSW-1:0] o_rem
);

    logic [rkd_pkg::DVW-1:0] r_q, n_q;
    logic [rkd_pkg::DSW-1:0] r_r, n_r;
    logic [rkd_pkg::DSW-1:0] r_dv;
    logic [rkd_pkg::DCW-1:0] r_cnt, n_cnt;
    logic                    r_busy, n_busy;
    logic                    r_done, n_done;
    logic [rkd_pkg::DSW:0]   trial;
    logic [rkd_pkg::DSW:0]   diff;

    always_comb begin
        trial  = {r_r, r_q[rkd_pkg::DVW-1]};
        diff   = trial - {1'b0, r_dv};
        n_q    = r_q;
        n_r    = r_r;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_q    = i_dividend;
            n_r    = '0;
            n_cnt  = rkd_pkg::DCW'(rkd_pkg::DVW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_q   = {r_q[rkd_pkg::DVW-2:0], !diff[rkd_pkg::DSW]};
            n_r   = diff[rkd_pkg::DSW] ? trial[rkd_pkg::DSW-1:0] : diff[rkd_pkg::DSW-1:0];
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == rkd_pkg::DCW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        if (i_start) begin
            r_dv <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

// File: src/rsa_keygen_and_decrypt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA key generation and decryption
// Derives n, e and d from two configured primes and decrypts single words.
// ----------------------------------------------------------------------------
//  Channel   Direction  Signals                                   Moves
//  in        sink       i_in_valid / o_in_ready                   command item
//  out       source     o_out_valid / i_out_ready                 result item
//  cfg       sink       i_cfg_we, i_cfg_idx, i_cfg_data           prime registers
//
// Key generation and decryption share one restoring divider and one 32x32
// multiplier under a sequencer. Decryption accepts the item, reduces the
// ciphertext modulo n, then per bit of the private exponent multiplies the
// base into the result if the bit is set and squares the base, reducing each
// product with the divider. Key generation runs one division and subtractive
// gcd steps per candidate exponent, searches for k and builds k*m + 1, and
// ends with one final division.
// Reset is synchronous and clears the keys; the primes return to 3 and 5.
// The block takes a new item only while its sequencer is idle. A finished
// result waits in the output register; while that register is still full the
// sequencer holds in its final state.
// ----------------------------------------------------------------------------
`include "rsa_keygen_and_decrypt_assert.svh"

module rsa_keygen_and_decrypt #(
    parameter int PRIME_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_cmd,
    input  logic [31:0]           i_cipher_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [1:0]            o_status,
    output logic [31:0]           o_modulus_n,
    output logic [31:0]           o_public_exp,
    output logic [31:0]           o_plain_word,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [PRIME_BITS-1:0] i_cfg_data
);

    // One-hot sequencer states.
    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_MN    = 15'b000000000000010,
        S_MM    = 15'b000000000000100,
        S_MCHK  = 15'b000000000001000,
        S_EMOD  = 15'b000000000010000,
        S_GCD   = 15'b000000000100000,
        S_KSRCH = 15'b000000001000000,
        S_KMUL  = 15'b000000010000000,
        S_DDIV  = 15'b000000100000000,
        S_BMOD  = 15'b000001000000000,
        S_PSTEP = 15'b000010000000000,
        S_PSQ   = 15'b000100000000000,
        S_PMUL  = 15'b001000000000000,
        S_PRED  = 15'b010000000000000,
        S_FIN   = 15'b100000000000000
    } t_state;

    localparam logic [PRIME_BITS-1:0] P_TWO = PRIME_BITS'(2);

    t_state r_state, n_state;

    // Configuration and key state.
    logic [PRIME_BITS-1:0] r_p, r_q;
    logic [31:0] r_n, n_n, r_e, n_e, r_d, n_d;
    logic        r_keys, n_keys;

    // Working registers.
    logic [31:0] r_ntmp, n_ntmp;
    logic [63:0] r_m, n_m;
    logic [7:0]  r_etry, n_etry;
    logic [7:0]  r_mr, n_mr;
    logic [7:0]  r_ga, n_ga, r_gb, n_gb;
    logic [7:0]  r_acc, n_acc, r_k, n_k;
    logic [71:0] r_num, n_num;
    logic [31:0] r_r, n_r, r_b, n_b, r_x, n_x;
    logic        r_sq, n_sq;
    logic [1:0]  r_status, n_status;
    logic [31:0] r_plain, n_plain;
    logic [63:0] r_prod;

    // Output register.
    logic        r_ovalid, n_ovalid;
    logic [1:0]  r_ost, n_ost;
    logic [31:0] r_on, n_on, r_oe, n_oe, r_op, n_op;

    // Multiplier and divider hookup.
    logic [31:0]              mul_a, mul_b;
    logic [63:0]              mul_p;
    logic                     div_start;
    logic [rkd_pkg::DVW-1:0]  div_dividend;
    logic [rkd_pkg::DSW-1:0]  div_divisor;
    logic                     div_done;
    logic [rkd_pkg::DVW-1:0]  div_quot;
    logic [rkd_pkg::DSW-1:0]  div_rem;

    logic [8:0]  acc_sum;
    logic [7:0]  acc_next;
    logic        accept;

    rkd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // The multiplier inputs follow the sequencer state; the product is
    // registered and used in the following state.
    always_comb begin
        mul_a = 32'(r_p);
        mul_b = 32'(r_q);
        if (r_state == S_MM) begin
            mul_a = 32'(r_p) - 32'd1;
            mul_b = 32'(r_q) - 32'd1;
        end else if (r_state == S_PSTEP) begin
            mul_a = r_r;
            mul_b = r_b;
        end else if (r_state == S_PSQ) begin
            mul_a = r_b;
            mul_b = r_b;
        end
    end
    assign mul_p = mul_a * mul_b;

    // Running value of k*(m mod e) + 1, reduced modulo e.
    assign acc_sum  = {1'b0, r_acc} + {1'b0, r_mr};
    assign acc_next = (acc_sum >= {1'b0, r_etry}) ? 8'(acc_sum - {1'b0, r_etry})
                                                  : acc_sum[7:0];

    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_e          = r_e;
        n_d          = r_d;
        n_keys       = r_keys;
        n_ntmp       = r_ntmp;
        n_m          = r_m;
        n_etry       = r_etry;
        n_mr         = r_mr;
        n_ga         = r_ga;
        n_gb         = r_gb;
        n_acc        = r_acc;
        n_k          = r_k;
        n_num        = r_num;
        n_r          = r_r;
        n_b          = r_b;
        n_x          = r_x;
        n_sq         = r_sq;
        n_status     = r_status;
        n_plain      = r_plain;
        n_ovalid     = r_ovalid && !i_out_ready;
        n_ost        = r_ost;
        n_on         = r_on;
        n_oe         = r_oe;
        n_op         = r_op;
        div_start    = 1'b0;
        div_dividend = rkd_pkg::DVW'(r_m);
        div_divisor  = rkd_pkg::DSW'(r_etry);

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_status = rkd_pkg::ST_OK;
                    n_plain  = '0;
                    if (i_cmd == rkd_pkg::CMD_KEYGEN) begin
                        if (r_p < P_TWO || r_q < P_TWO) begin
                            n_n      = '0;
                            n_e      = '0;
                            n_d      = '0;
                            n_keys   = 1'b0;
                            n_status = rkd_pkg::ST_BAD_PRIMES;
                            n_state  = S_FIN;
                        end else begin
                            n_state = S_MN;
                        end
                    end else if (!r_keys) begin
                        n_status = rkd_pkg::ST_NO_KEYS;
                        n_state  = S_FIN;
                    end else if (r_n <= 32'd1) begin
                        n_state = S_FIN;
                    end else begin
                        // Reduce the ciphertext modulo n first.
                        div_start    = 1'b1;
                        div_dividend = rkd_pkg::DVW'(i_cipher_word);
                        div_divisor  = rkd_pkg::DSW'(r_n);
                        n_state      = S_BMOD;
                    end
                end
            end
            S_MN: begin
                n_state = S_MM;
            end
            S_MM: begin
                n_ntmp  = r_prod[31:0];
                n_state = S_MCHK;
            end
            S_MCHK: begin
                n_m = r_prod;
                if (r_prod <= 64'd1) begin
                    n_n      = '0;
                    n_e      = '0;
                    n_d      = '0;
                    n_keys   = 1'b0;
                    n_status = rkd_pkg::ST_BAD_PRIMES;
                    n_state  = S_FIN;
                end else begin
                    n_etry       = 8'd2;
                    div_start    = 1'b1;
                    div_dividend = rkd_pkg::DVW'(r_prod);
                    div_divisor  = rkd_pkg::DSW'(2);
                    n_state      = S_EMOD;
                end
            end
            S_EMOD: begin
                if (div_done) begin
                    n_mr    = div_rem[7:0];
                    n_ga    = r_etry;
                    n_gb    = div_rem[7:0];
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                // Subtractive gcd of the candidate and m mod candidate.
                if (r_gb == 8'd0) begin
                    if (r_ga == 8'd1) begin
                        n_acc   = 8'd1;
                        n_k     = 8'd0;
                        n_state = S_KSRCH;
                    end else begin
                        n_etry       = r_etry + 8'd1;
                        div_start    = 1'b1;
                        div_divisor  = rkd_pkg::DSW'(r_etry + 8'd1);
                        n_state      = S_EMOD;
                    end
                end else if (r_ga >= r_gb) begin
                    n_ga = r_ga - r_gb;
                end else begin
                    n_ga = r_gb;
                    n_gb = r_ga;
                end
            end
            S_KSRCH: begin
                // Smallest k with k*m + 1 divisible by e gives d = (k*m + 1) / e.
                n_acc = acc_next;
                n_k   = r_k + 8'd1;
                if (acc_next == 8'd0) begin
                    n_num   = rkd_pkg::DVW'(1);
                    n_state = S_KMUL;
                end
            end
            S_KMUL: begin
                if (r_k == 8'd0) begin
                    div_start    = 1'b1;
                    div_dividend = r_num;
                    n_state      = S_DDIV;
                end else begin
                    n_num = r_num + rkd_pkg::DVW'(r_m);
                    n_k   = r_k - 8'd1;
                end
            end
            S_DDIV: begin
                if (div_done) begin
                    n_d     = div_quot[31:0];
                    n_n     = r_ntmp;
                    n_e     = 32'(r_etry);
                    n_keys  = 1'b1;
                    n_state = S_FIN;
                end
            end
            S_BMOD: begin
                if (div_done) begin
                    n_b     = div_rem[31:0];
                    n_r     = 32'd1;
                    n_x     = r_d;
                    n_state = S_PSTEP;
                end
            end
            S_PSTEP: begin
                if (r_x == 32'd0) begin
                    n_plain = r_r;
                    n_state = S_FIN;
                end else if (r_x[0]) begin
                    n_sq    = 1'b0;
                    n_state = S_PMUL;
                end else begin
                    n_sq    = 1'b1;
                    n_state = S_PSQ;
                end
            end
            S_PSQ: begin
                n_sq    = 1'b1;
                n_state = S_PMUL;
            end
            S_PMUL: begin
                div_start    = 1'b1;
                div_dividend = rkd_pkg::DVW'(r_prod);
                div_divisor  = rkd_pkg::DSW'(r_n);
                n_state      = S_PRED;
            end
            S_PRED: begin
                if (div_done) begin
                    if (!r_sq) begin
                        n_r     = div_rem[31:0];
                        n_state = S_PSQ;
                    end else begin
                        n_b     = div_rem[31:0];
                        n_x     = r_x >> 1;
                        n_state = S_PSTEP;
                    end
                end
            end
            S_FIN: begin
                // Wait for the output register to be free.
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_ost    = r_status;
                    n_on     = r_n;
                    n_oe     = r_e;
                    n_op     = r_plain;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_p      <= PRIME_BITS'(3);
            r_q      <= PRIME_BITS'(5);
            r_n      <= '0;
            r_e      <= '0;
            r_d      <= '0;
            r_keys   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_n      <= n_n;
            r_e      <= n_e;
            r_d      <= n_d;
            r_keys   <= n_keys;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                if (i_cfg_idx == 1'b0) begin
                    r_p <= i_cfg_data;
                end else begin
                    r_q <= i_cfg_data;
                end
            end
        end
        r_ntmp   <= n_ntmp;
        r_m      <= n_m;
        r_etry   <= n_etry;
        r_mr     <= n_mr;
        r_ga     <= n_ga;
        r_gb     <= n_gb;
        r_acc    <= n_acc;
        r_k      <= n_k;
        r_num    <= n_num;
        r_r      <= n_r;
        r_b      <= n_b;
        r_x      <= n_x;
        r_sq     <= n_sq;
        r_status <= n_status;
        r_plain  <= n_plain;
        r_prod   <= mul_p;
        r_ost    <= n_ost;
        r_on     <= n_on;
        r_oe     <= n_oe;
        r_op     <= n_op;
    end

    assign o_out_valid  = r_ovalid;
    assign o_status     = r_ost;
    assign o_modulus_n  = r_on;
    assign o_public_exp = r_oe;
    assign o_plain_word = r_op;

    // An accepted item always takes the sequencer out of idle.
    `RKD_ASSERT_RST(a_busy_after_accept, i_clk, i_rst_n, accept |=> !o_in_ready)
    // Held keys always carry a public exponent of at least two.
    `RKD_ASSERT_RST(a_keys_have_exp, i_clk, i_rst_n, r_keys |-> (r_e >= 32'd2))
    // A missing-keys status is only produced while no keys are held.
    `RKD_ASSERT_RST(a_no_keys_status, i_clk, i_rst_n,
        (r_state == S_FIN && r_status == rkd_pkg::ST_NO_KEYS) |-> !r_keys)

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RSA key generation and decryption testbench
// Drives command items with random idling and output stalls, walks the prime
// registers through several settings and compares every result item against
// an in-bench key and decryption predictor.
// ----------------------------------------------------------------------------
module tb;

    localparam int PRIME_BITS = 16;
    // Register indexes of the configuration port.
    localparam logic REG_P = 1'b0;
    localparam logic REG_Q = 1'b1;

    // One result item as the block reports it.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] modulus_n;
        logic [31:0] public_exp;
        logic [31:0] plain_word;
    } t_rsa_result;

    // The scoreboard keeps the results still owed by the block, oldest first.
    class t_rsa_scoreboard;
        t_rsa_result owed[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        function void note_item(t_rsa_result r);
            owed.push_back(r);
        endfunction

        function void check_result(t_rsa_result act);
            t_rsa_result e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result item status=%0d n=%0h e=%0h plain=%0h",
                         $time, act.status, act.modulus_n, act.public_exp, act.plain_word);
                errors++;
                return;
            end
            e = owed.pop_front();
            if (e.status !== act.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, act.status);
                errors++;
            end
            if (e.modulus_n !== act.modulus_n) begin
                $display("%0t: modulus_n expected %0h actual %0h",
                         $time, e.modulus_n, act.modulus_n);
                errors++;
            end
            if (e.public_exp !== act.public_exp) begin
                $display("%0t: public_exp expected %0h actual %0h",
                         $time, e.public_exp, act.public_exp);
                errors++;
            end
            if (e.plain_word !== act.plain_word) begin
                $display("%0t: plain_word expected %0h actual %0h",
                         $time, e.plain_word, act.plain_word);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_cmd;
    logic [31:0]           i_cipher_word;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [1:0]            o_status;
    logic [31:0]           o_modulus_n;
    logic [31:0]           o_public_exp;
    logic [31:0]           o_plain_word;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [PRIME_BITS-1:0] i_cfg_data;

    rsa_keygen_and_decrypt #(.PRIME_BITS(PRIME_BITS)) dut (.*);

    t_rsa_scoreboard sb = new();

    // Shadow copy of the block's registers and key state.
    logic [PRIME_BITS-1:0] shadow_p, shadow_q;
    logic [31:0]           key_n, key_e, key_d;
    logic                  key_ok;
    // While set, neither side idles: a long stretch of back-to-back traffic.
    logic                  no_idle;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Greatest common divisor on 64-bit values.
    function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
        longint unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // Inverse of e modulo m by the extended Euclidean algorithm; m < 2^32 here,
    // so signed 64-bit coefficients cannot overflow.
    function automatic longint unsigned inverse_mod(longint unsigned e, longint unsigned m);
        longint r0, r1, t0, t1, qt, tmp;
        r0 = m;
        r1 = e % m;
        t0 = 0;
        t1 = 1;
        while (r1 != 0) begin
            qt = r0 / r1;
            tmp = r0 - qt * r1; r0 = r1; r1 = tmp;
            tmp = t0 - qt * t1; t0 = t1; t1 = tmp;
        end
        t0 = t0 % longint'(m);
        if (t0 < 0) t0 += m;
        return t0;
    endfunction

    // base^x mod n by square and multiply; products stay below 2^64.
    function automatic logic [31:0] power_mod(logic [31:0] base, logic [31:0] x,
                                              logic [31:0] n);
        longint unsigned r, b;
        if (n <= 1) return '0;
        r = 1;
        b = base % n;
        for (int i = 0; i < 32; i++) begin
            if (x[i]) r = (r * b) % n;
            b = (b * b) % n;
        end
        return r[31:0];
    endfunction

    // Works out the result item of one command and updates the held keys.
    function automatic t_rsa_result predict_rsa(logic cmd, logic [31:0] cw);
        t_rsa_result     r;
        longint unsigned m, e;
        r = '0;
        if (cmd == rkd_pkg::CMD_KEYGEN) begin
            m = 0;
            if (shadow_p >= 2 && shadow_q >= 2)
                m = longint'(shadow_p - 1) * longint'(shadow_q - 1);
            if (m <= 1) begin
                key_n = '0; key_e = '0; key_d = '0; key_ok = 1'b0;
                r.status = rkd_pkg::ST_BAD_PRIMES;
            end else begin
                e = 2;
                while (gcd_of(e, m) != 1) e++;
                key_n = 32'(longint'(shadow_p) * longint'(shadow_q));
                key_e = e[31:0];
                key_d = 32'(inverse_mod(e, m));
                key_ok = 1'b1;
                r.status = rkd_pkg::ST_OK;
            end
        end else if (!key_ok) begin
            r.status = rkd_pkg::ST_NO_KEYS;
        end else begin
            r.status = rkd_pkg::ST_OK;
            r.plain_word = power_mod(cw, key_d, key_n);
        end
        r.modulus_n  = key_n;
        r.public_exp = key_e;
        return r;
    endfunction

    // Sends one command item. Valid stays high after acceptance so that a
    // following item can reuse the same falling edge without a glitch.
    task automatic send_item(logic cmd, logic [31:0] cw);
        if (!no_idle && $urandom_range(99) < 33) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_cmd         = cmd;
        i_cipher_word = cw;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(predict_rsa(cmd, cw));
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every owed result has come back.
    task automatic drain;
        i_in_valid = 1'b0;
        while (sb.owed.size() != 0) @(negedge i_clk);
    endtask

    // Writes one prime register; only called while the block is idle.
    task automatic write_prime(logic idx, logic [PRIME_BITS-1:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (idx == REG_P) shadow_p = value;
        else shadow_q = value;
    endtask

    task automatic set_primes(logic [PRIME_BITS-1:0] p, logic [PRIME_BITS-1:0] q);
        drain();
        write_prime(REG_P, p);
        write_prime(REG_Q, q);
    endtask

    function automatic logic [PRIME_BITS-1:0] pick_prime();
        logic [PRIME_BITS-1:0] primes[12] = '{2, 3, 5, 7, 11, 13, 251, 257,
                                              4093, 32749, 65521, 65519};
        int k;
        k = $urandom_range(99);
        if (k < 70) return primes[$urandom_range(11)];
        if (k < 95) return PRIME_BITS'($urandom_range(65535, 2));
        return PRIME_BITS'($urandom_range(1, 0));
    endfunction

    // Output side: random stalls, sampled at the rising edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else i_out_ready <= no_idle || ($urandom_range(99) >= 33);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result('{o_status, o_modulus_n, o_public_exp, o_plain_word});
    end

    initial begin
        #400_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cmd = rkd_pkg::CMD_KEYGEN;
        i_cipher_word = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_P;
        i_cfg_data = '0;
        no_idle = 1'b0;
        shadow_p = 3;
        shadow_q = 5;
        key_n = '0; key_e = '0; key_d = '0; key_ok = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Decryption before any key exists, then keys from the reset primes.
        send_item(rkd_pkg::CMD_DECRYPT, 32'h0000_0007);
        send_item(rkd_pkg::CMD_KEYGEN, 32'hFFFF_FFFF);
        send_item(rkd_pkg::CMD_DECRYPT, 32'h0000_0000);
        send_item(rkd_pkg::CMD_DECRYPT, 32'hFFFF_FFFF);
        send_item(rkd_pkg::CMD_DECRYPT, 32'h0000_000E);

        // Largest primes: the modulus nearly fills 32 bits.
        set_primes(16'd65521, 16'd65519);
        send_item(rkd_pkg::CMD_KEYGEN, 32'h0);
        send_item(rkd_pkg::CMD_DECRYPT, 32'hFFFF_FFFF);
        send_item(rkd_pkg::CMD_DECRYPT, 32'hAAAA_5555);

        // p = q = 2 leaves m = 1: keys are cleared and decryption is refused.
        set_primes(16'd2, 16'd2);
        send_item(rkd_pkg::CMD_KEYGEN, 32'h0);
        send_item(rkd_pkg::CMD_DECRYPT, 32'h1234_5678);

        // Primes below two are degenerate as well.
        set_primes(16'd0, 16'd7);
        send_item(rkd_pkg::CMD_KEYGEN, 32'h0);
        set_primes(16'd65535, 16'd1);
        send_item(rkd_pkg::CMD_KEYGEN, 32'h0);

        // Smallest valid pair, and a large even m from two equal values.
        set_primes(16'd2, 16'd3);
        send_item(rkd_pkg::CMD_KEYGEN, 32'h0);
        send_item(rkd_pkg::CMD_DECRYPT, 32'h0000_0005);
        set_primes(16'd65535, 16'd65535);
        send_item(rkd_pkg::CMD_KEYGEN, 32'h0);
        send_item(rkd_pkg::CMD_DECRYPT, 32'h8000_0001);

        // Random phases: new primes, a key derivation, then a burst of words.
        for (int i = 0; i < 124; i++) begin
            no_idle = (i >= 60 && i < 95);
            if (i % 20 == 0) begin
                set_primes(pick_prime(), pick_prime());
                send_item(rkd_pkg::CMD_KEYGEN, $urandom());
            end else if ($urandom_range(99) < 5) begin
                send_item(rkd_pkg::CMD_KEYGEN, $urandom());
            end else begin
                send_item(rkd_pkg::CMD_DECRYPT, $urandom());
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (100) @(negedge i_clk);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
